FILE: hw/rtl/bmpps_pkg.sv
// Shared types and constants for the BMP pixel stream decoder.
// No dependencies; used by bmpps_regs, bmpps_decode and the top level.
package bmpps_pkg;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam int COORD_W = 13;

    localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [2:0] REG_HAS_ALPHA    = 3'd2;
    localparam logic [2:0] REG_ORIGIN_X     = 3'd3;
    localparam logic [2:0] REG_ORIGIN_Y     = 3'd4;

    typedef struct packed {
        logic signed [13:0] image_width;
        logic signed [13:0] image_height;
        logic               has_alpha;
        logic [11:0]        origin_x;
        logic [11:0]        origin_y;
    } t_cfg;

    typedef struct packed {
        logic               last_pixel;
        logic [31:0]        argb;
        logic [COORD_W-1:0] screen_y;
        logic [COORD_W-1:0] screen_x;
    } t_pix;

endpackage

FILE: hw/rtl/bmpps_regs.sv
// Configuration register file with an APB-style access port.
// Depends on bmpps_pkg for the register codes and the t_cfg struct.
module bmpps_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bmpps_pkg::ADDR_W-1:0]  paddr,
    input  logic [bmpps_pkg::DATA_W-1:0]  pwdata,
    output logic [bmpps_pkg::DATA_W-1:0]  prdata,
    output logic                          pready,
    output bmpps_pkg::t_cfg               o_cfg,
    output logic                          o_clear
);

    bmpps_pkg::t_cfg r_cfg;
    bmpps_pkg::t_cfg n_cfg;
    logic            wr_en;
    logic            known;
    logic [2:0]      reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb begin
        n_cfg = r_cfg;
        known = 1'b1;
        unique case (reg_idx)
            bmpps_pkg::REG_IMAGE_WIDTH:  n_cfg.image_width  = pwdata[13:0];
            bmpps_pkg::REG_IMAGE_HEIGHT: n_cfg.image_height = pwdata[13:0];
            bmpps_pkg::REG_HAS_ALPHA:    n_cfg.has_alpha    = pwdata[0];
            bmpps_pkg::REG_ORIGIN_X:     n_cfg.origin_x     = pwdata[11:0];
            bmpps_pkg::REG_ORIGIN_Y:     n_cfg.origin_y     = pwdata[11:0];
            default:                     known              = 1'b0;
        endcase
    end

    always_comb begin
        unique case (reg_idx)
            bmpps_pkg::REG_IMAGE_WIDTH:  prdata = {18'd0, r_cfg.image_width};
            bmpps_pkg::REG_IMAGE_HEIGHT: prdata = {18'd0, r_cfg.image_height};
            bmpps_pkg::REG_HAS_ALPHA:    prdata = {31'd0, r_cfg.has_alpha};
            bmpps_pkg::REG_ORIGIN_X:     prdata = {20'd0, r_cfg.origin_x};
            bmpps_pkg::REG_ORIGIN_Y:     prdata = {20'd0, r_cfg.origin_y};
            default:                     prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (wr_en) begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg   = r_cfg;
    assign o_clear = wr_en && known;

endmodule

FILE: hw/rtl/bmpps_decode.sv
// Byte-level pixel assembler: tracks byte, column, row and padding position
// and forms one pixel result with screen coordinates. Depends on bmpps_pkg.
module bmpps_decode #(
    parameter int MAX_SIDE = 4096
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bmpps_pkg::t_cfg i_cfg,
    input  logic            i_clear,
    input  logic            i_valid,
    input  logic [7:0]      i_byte,
    output logic            o_valid,
    output bmpps_pkg::t_pix o_pix
);

    localparam int CNT_W  = $clog2(MAX_SIDE);
    localparam int SIDE_W = $clog2(MAX_SIDE + 1);
    localparam int MW     = (SIDE_W > 14) ? SIDE_W : 14;
    localparam int XW     = (SIDE_W > bmpps_pkg::COORD_W) ? SIDE_W : bmpps_pkg::COORD_W;

    logic [1:0]       r_byte_idx, n_byte_idx;
    logic [23:0]      r_partial,  n_partial;
    logic [CNT_W-1:0] r_col,      n_col;
    logic [CNT_W-1:0] r_row,      n_row;
    logic [1:0]       r_pad_cnt,  n_pad_cnt;
    logic             r_in_pad,   n_in_pad;

    logic [13:0]       w_mag, h_mag;
    logic [MW-1:0]     w_sat, h_sat;
    logic [SIDE_W-1:0] cols, rows;
    logic [1:0]        pad;
    logic [SIDE_W-1:0] col_inc, row_inc;
    logic              col_end, row_end;
    logic [1:0]        pad_inc;
    logic [XW-1:0]     sx_full, sy_full;
    logic              emit;
    logic [7:0]        alpha;

    assign w_mag = i_cfg.image_width[13]  ? (~i_cfg.image_width + 14'd1)  : i_cfg.image_width;
    assign h_mag = i_cfg.image_height[13] ? (~i_cfg.image_height + 14'd1) : i_cfg.image_height;
    assign w_sat = (MW'(w_mag) > MW'(MAX_SIDE)) ? MW'(MAX_SIDE) : MW'(w_mag);
    assign h_sat = (MW'(h_mag) > MW'(MAX_SIDE)) ? MW'(MAX_SIDE) : MW'(h_mag);
    assign cols  = w_sat[SIDE_W-1:0];
    assign rows  = h_sat[SIDE_W-1:0];

    // Three bytes per pixel leave (width mod 4) bytes of padding per row.
    assign pad = i_cfg.has_alpha ? 2'd0 : cols[1:0];

    assign col_inc = SIDE_W'(r_col) + SIDE_W'(1);
    assign row_inc = SIDE_W'(r_row) + SIDE_W'(1);
    assign col_end = col_inc >= cols;
    assign row_end = row_inc >= rows;
    assign pad_inc = r_pad_cnt + 2'd1;

    assign sx_full = i_cfg.image_width[13]
                   ? XW'(i_cfg.origin_x) + XW'(cols) - XW'(1) - XW'(r_col)
                   : XW'(i_cfg.origin_x) + XW'(r_col);
    assign sy_full = i_cfg.image_height[13]
                   ? XW'(i_cfg.origin_y) + XW'(r_row)
                   : XW'(i_cfg.origin_y) + XW'(rows) - XW'(1) - XW'(r_row);

    always_comb begin
        n_byte_idx = r_byte_idx;
        n_partial  = r_partial;
        n_col      = r_col;
        n_row      = r_row;
        n_pad_cnt  = r_pad_cnt;
        n_in_pad   = r_in_pad;
        emit       = 1'b0;
        alpha      = 8'd0;

        if (i_valid && (cols != '0) && (rows != '0)) begin
            if (r_in_pad) begin
                n_pad_cnt = pad_inc;
                if (pad_inc >= pad) begin
                    n_col     = '0;
                    n_in_pad  = 1'b0;
                    n_pad_cnt = 2'd0;
                    n_row     = row_end ? '0 : row_inc[CNT_W-1:0];
                end
            end else begin
                case (r_byte_idx)
                    2'd0: begin
                        n_partial[7:0] = i_byte;
                        n_byte_idx     = 2'd1;
                    end
                    2'd1: begin
                        n_partial[15:8] = i_byte;
                        n_byte_idx      = 2'd2;
                    end
                    2'd2: begin
                        n_partial[23:16] = i_byte;
                        if (i_cfg.has_alpha) begin
                            n_byte_idx = 2'd3;
                        end else begin
                            emit = 1'b1;
                        end
                    end
                    default: begin
                        alpha = i_byte;
                        emit  = 1'b1;
                    end
                endcase

                if (emit) begin
                    n_byte_idx = 2'd0;
                    n_partial  = '0;
                    if (col_end) begin
                        if (pad != 2'd0) begin
                            n_in_pad  = 1'b1;
                            n_pad_cnt = 2'd0;
                        end else begin
                            n_col = '0;
                            n_row = row_end ? '0 : row_inc[CNT_W-1:0];
                        end
                    end else begin
                        n_col = col_inc[CNT_W-1:0];
                    end
                end
            end
        end
    end

    always_comb begin
        o_valid          = emit;
        o_pix.screen_x   = sx_full[bmpps_pkg::COORD_W-1:0];
        o_pix.screen_y   = sy_full[bmpps_pkg::COORD_W-1:0];
        o_pix.last_pixel = row_end && col_end;
        if (r_byte_idx == 2'd2) begin
            o_pix.argb = {alpha, i_byte, r_partial[15:0]};
        end else begin
            o_pix.argb = {alpha, r_partial};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_byte_idx <= 2'd0;
            r_partial  <= '0;
            r_col      <= '0;
            r_row      <= '0;
            r_pad_cnt  <= 2'd0;
            r_in_pad   <= 1'b0;
        end else begin
            r_byte_idx <= n_byte_idx;
            r_partial  <= n_partial;
            r_col      <= n_col;
            r_row      <= n_row;
            r_pad_cnt  <= n_pad_cnt;
            r_in_pad   <= n_in_pad;
        end
    end

endmodule

FILE: hw/rtl/bmp_pixel_stream_to_screen.sv
// Top level of the BMP pixel stream decoder: register port, decoder and
// output buffering. Depends on bmpps_pkg, bmpps_regs and bmpps_decode.
//
// The slave stream carries the pixel array of a 24-bit or 32-bit BMP image,
// one byte per transaction in file order. The master stream carries one
// transaction per finished pixel: screen x, screen y and ARGB color in tdata,
// with tlast set on the final pixel of the image. Padding bytes at the end of
// each row are consumed and produce no transaction.
// Program width, height, alpha mode and origin over the APB port while the
// streams are idle; every write to a known register restarts the image.
// A finished pixel is registered in the result or, on a stall, the skid register.
// One byte is accepted every cycle as long as the receiver keeps
// up; the throughput is set by the single decode stage.
// When the receiver stalls, a result register and one skid register hold
// pixels, and tready drops only once the skid register is full.
// Reset clears all configuration registers, the decode position and both output slots.
module bmp_pixel_stream_to_screen #(
    parameter int MAX_SIDE = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bmpps_pkg::ADDR_W-1:0]  paddr,
    input  logic [bmpps_pkg::DATA_W-1:0]  pwdata,
    output logic [bmpps_pkg::DATA_W-1:0]  prdata,
    output logic                          pready,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [7:0]                    i_s_tdata,   // data_byte[7:0]
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // screen_x[12:0], screen_y[25:13], argb[57:26], zero[63:58]
    output logic [63:0]                   o_m_tdata,
    output logic                          o_m_tlast
);

    bmpps_pkg::t_cfg cfg;
    logic            clear;
    logic            res_vld;
    bmpps_pkg::t_pix res_pix;
    logic            in_fire;
    logic            out_free;

    logic            r_out_vld;
    bmpps_pkg::t_pix r_out;
    logic            r_skid_vld;
    bmpps_pkg::t_pix r_skid;

    bmpps_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg),
        .o_clear (clear)
    );

    assign o_s_tready = !r_skid_vld;
    assign in_fire    = i_s_tvalid && o_s_tready;

    bmpps_decode #(
        .MAX_SIDE (MAX_SIDE)
    ) u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_clear (clear),
        .i_valid (in_fire),
        .i_byte  (i_s_tdata),
        .o_valid (res_vld),
        .o_pix   (res_pix)
    );

    assign out_free = !r_out_vld || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (out_free) begin
            if (r_skid_vld) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end else begin
                r_out_vld <= res_vld;
            end
        end else if (res_vld) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_vld ? r_skid : res_pix;
        end
        if (!out_free && res_vld) begin
            r_skid <= res_pix;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {6'd0, r_out.argb, r_out.screen_y, r_out.screen_x};
    assign o_m_tlast  = r_out.last_pixel;

endmodule
